// ===== rtl/core/sblc_pkg.sv =====
// Shared constants and controller/datapath interface types for the size-budget LRU cache.
`timescale 1ns / 1ps
package sblc_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int RANK_W     = IDX_W;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int DATA_W     = 32;
    localparam int EVC_W      = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EVICT,
        S_INSERT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic lookup;
        logic evict;
        logic insert;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic oversize;
        logic over_budget;
        logic empty;
        logic full;
    } sts_t;

endpackage

// ===== rtl/core/sblc_ctrl.sv =====
// Request sequencing state machine for the size-budget LRU cache.
`timescale 1ns / 1ps
module sblc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  sblc_pkg::sts_t sts,
    output sblc_pkg::cmd_t cmd
);
    import sblc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   evict_now;

    assign evict_now = (sts.over_budget && !sts.empty) || sts.full;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                if (sts.hit || sts.oversize)
                    state_next = S_DONE;
                else
                    state_next = S_EVICT;
            end
            S_EVICT:
            begin
                // keep evicting while over budget; a full table costs one more
                if (!(sts.over_budget && !sts.empty))
                    state_next = S_INSERT;
            end
            S_INSERT:
                state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:   cmd.latch    = in_valid;
            S_LOOKUP: cmd.lookup   = 1'b1;
            S_EVICT:  cmd.evict    = evict_now;
            S_INSERT: cmd.insert   = 1'b1;
            S_DONE:   cmd.load_out = !out_valid_reg || out_ready;
            default:  cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/sblc_dp.sv =====
// Slot table, LRU ranks, byte accounting and result registers.
`timescale 1ns / 1ps
module sblc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sblc_pkg::cmd_t                cmd,
    output sblc_pkg::sts_t                sts,
    input  logic                          cfg_wr_en,
    input  logic [sblc_pkg::DATA_W-1:0]   cfg_wr_data,
    input  logic [sblc_pkg::DATA_W-1:0]   item_key,
    input  logic [sblc_pkg::DATA_W-1:0]   item_size,
    output logic                          hit,
    output logic                          stored,
    output logic [sblc_pkg::EVC_W-1:0]    evicted_count,
    output logic [sblc_pkg::DATA_W-1:0]   bytes_in_use
);
    import sblc_pkg::*;

    logic [DATA_W-1:0] budget_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] size_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [DATA_W-1:0] slot_key_reg  [SLOT_COUNT];
    logic [DATA_W-1:0] slot_size_reg [SLOT_COUNT];
    logic [RANK_W-1:0] rank_reg      [SLOT_COUNT];
    logic [CNT_W-1:0]  count_reg;
    logic [DATA_W-1:0] resident_reg;
    logic [EVC_W-1:0]  evc_reg;
    logic              hit_res_reg;
    logic              stored_res_reg;

    logic              hit_out_reg;
    logic              stored_out_reg;
    logic [EVC_W-1:0]  evc_out_reg;
    logic [DATA_W-1:0] bytes_out_reg;

    logic [SLOT_COUNT-1:0] match_vec;
    logic [SLOT_COUNT-1:0] oldest_vec;
    logic [RANK_W-1:0]     hit_rank;
    logic [DATA_W-1:0]     oldest_size;
    logic [IDX_W-1:0]      free_idx;
    logic [CNT_W-1:0]      oldest_rank;
    logic [DATA_W:0]       need_bytes;

    assign oldest_rank = count_reg - 1'b1;

    always_comb
    begin
        hit_rank    = '0;
        oldest_size = '0;
        free_idx    = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            match_vec[i]  = valid_reg[i] && (slot_key_reg[i] == key_reg);
            oldest_vec[i] = valid_reg[i] && (CNT_W'(rank_reg[i]) == oldest_rank);
            if (match_vec[i])
                hit_rank = hit_rank | rank_reg[i];
            if (oldest_vec[i])
                oldest_size = oldest_size | slot_size_reg[i];
        end
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_idx = IDX_W'(i);
        end
    end

    assign need_bytes      = {1'b0, resident_reg} + {1'b0, size_reg};
    assign sts.hit         = |match_vec;
    assign sts.oversize    = size_reg > budget_reg;
    assign sts.over_budget = need_bytes > {1'b0, budget_reg};
    assign sts.empty       = (count_reg == '0);
    assign sts.full        = (count_reg == CNT_W'(SLOT_COUNT));

    // key and size storage carries no reset
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            key_reg  <= item_key;
            size_reg <= item_size;
        end
        if (cmd.insert)
        begin
            slot_key_reg[free_idx]  <= key_reg;
            slot_size_reg[free_idx] <= size_reg;
        end
        if (cmd.load_out)
        begin
            hit_out_reg    <= hit_res_reg;
            stored_out_reg <= stored_res_reg;
            evc_out_reg    <= evc_reg;
            bytes_out_reg  <= resident_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg     <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            resident_reg   <= '0;
            evc_reg        <= '0;
            hit_res_reg    <= 1'b0;
            stored_res_reg <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                budget_reg <= cfg_wr_data;
            if (cmd.latch)
                evc_reg <= '0;
            if (cmd.lookup)
            begin
                hit_res_reg    <= |match_vec;
                stored_res_reg <= |match_vec;
                if (|match_vec)
                begin
                    // promote the hit entry, age those that were newer
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (match_vec[i])
                            rank_reg[i] <= '0;
                        else if (valid_reg[i] && rank_reg[i] < hit_rank)
                            rank_reg[i] <= rank_reg[i] + 1'b1;
                    end
                end
            end
            if (cmd.evict)
            begin
                valid_reg    <= valid_reg & ~oldest_vec;
                count_reg    <= count_reg - 1'b1;
                resident_reg <= resident_reg - oldest_size;
                if (evc_reg != '1)
                    evc_reg <= evc_reg + 1'b1;
            end
            if (cmd.insert)
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (valid_reg[i])
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                end
                rank_reg[free_idx]  <= '0;
                valid_reg[free_idx] <= 1'b1;
                count_reg           <= count_reg + 1'b1;
                resident_reg        <= need_bytes[DATA_W-1:0];
                stored_res_reg      <= 1'b1;
            end
        end
    end

    assign hit           = hit_out_reg;
    assign stored        = stored_out_reg;
    assign evicted_count = evc_out_reg;
    assign bytes_in_use  = bytes_out_reg;

    a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(count_reg))
        else $error("slot count out of step with valid bits");

    a_single_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(oldest_vec) && (sts.empty || $onehot(oldest_vec)))
        else $error("oldest entry not unique");

    a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> !sts.full)
        else $error("insert into a full table");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("key resident in more than one slot");

endmodule

// ===== rtl/core/size_budget_lru_cache_unit.sv =====
// Top level of the size-budget LRU cache: controller plus datapath.
//
//  channel   direction  handshake             payload
//  request   in         in_valid / in_ready   item_key, item_size
//  result    out        out_valid / out_ready hit, stored, evicted_count, bytes_in_use
//  config    in         cfg_wr_en             cfg_wr_data (byte budget)
//
// A hit or an oversized miss goes from lookup straight to the done state; a stored
// miss passes through the evict state, evicting entries until the budget is met (a
// full table always loses its oldest entry), then insert, then done. Done loads the
// result once any held result is taken, raises out_valid and returns to idle.
// One request is in flight at a time.
// Reset clears the valid bits, ranks, byte total and budget; no clearing pass.
// A result held by a stalled consumer blocks only the finish of the next request.
`timescale 1ns / 1ps
module size_budget_lru_cache_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sblc_pkg::DATA_W-1:0] item_key,
    input  logic [sblc_pkg::DATA_W-1:0] item_size,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        hit,
    output logic                        stored,
    output logic [sblc_pkg::EVC_W-1:0]  evicted_count,
    output logic [sblc_pkg::DATA_W-1:0] bytes_in_use,
    input  logic                        cfg_wr_en,
    input  logic [sblc_pkg::DATA_W-1:0] cfg_wr_data
);
    import sblc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sblc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sblc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .item_key      (item_key),
        .item_size     (item_size),
        .hit           (hit),
        .stored        (stored),
        .evicted_count (evicted_count),
        .bytes_in_use  (bytes_in_use)
    );

endmodule
